FILE: hdl/polyline_arc_length_sampler_core_assert.svh
// Assertion macros used by the checker file.
`ifndef POLYLINE_ARC_LENGTH_SAMPLER_CORE_ASSERT_SVH
`define POLYLINE_ARC_LENGTH_SAMPLER_CORE_ASSERT_SVH
// Implication checked every clock, quiet during reset.
`define PALS_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("same-cycle check failed");
// Next-cycle implication checked every clock, quiet during reset.
`define PALS_ASSERT_NXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("next-cycle check failed");
`endif

FILE: hdl/pals_pkg.sv
package pals_pkg;
  localparam int MAX_POINTS = 256;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [31:0] LEN_MAX = 32'h7FFF_FFFF;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_STORE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Stored point: x, y, heading, speed, s.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        heading;
    logic signed [15:0] speed;
    logic [31:0]        s;
  } point_t;

  localparam int PT_W = $bits(point_t);

  typedef struct packed {
    logic        op;
    logic        start_new;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [15:0] point_heading;
    logic signed [15:0] point_speed;
    logic signed [31:0] query_s;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic [15:0] out_heading;
    logic signed [15:0] out_speed;
    logic signed [31:0] out_s;
  } out_beat_t;
endpackage

FILE: hdl/pals_stream_if.sv
interface pals_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/pals_ram.sv
module pals_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/pals_div.sv
// Restoring divider: 49-bit dividend by 32-bit divisor, one quotient bit a cycle.
module pals_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [48:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [48:0] quo
);
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] rem;
  logic [48:0] q;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[48]} - {1'b0, den};

  // Shift one dividend bit in, subtract when it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 6'd1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd49;
        rem  <= '0;
        q    <= num;
      end else if (busy) begin
        if (!trial[32]) rem <= trial;
        else rem <= {rem[31:0], q[48]};
        q <= {q[47:0], !trial[32]};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end
  assign quo = q;
endmodule

FILE: hdl/polyline_arc_length_sampler_core.sv
// Polyline arc-length sampler.
// Channels: in_ch (sink) carries one command beat, out_ch (source) one result
// beat per command. Append (op 0) stores a point and accumulates the
// Euclidean distance to the previous point; sample (op 1) returns the
// interpolated point at arc length query_s.
// Sequence: an append runs three squaring steps, 32 root steps and one store
// step; an append with start_new, a dropped append and a sample on an empty
// path go straight to the result. A clamped sample does three reads; an
// interpolated sample does three reads, a binary search of three phases per
// step, a fetch of the pair, a start of the 49-step divide for t and four
// lerp steps, one field each. in_ch.ready is high only in idle, so one
// command is in flight and the next beat is taken only once the previous
// result has been accepted.
// Reset clears the point count and running length; the point memory holds
// stale data that is never read. A stalled receiver holds the result beat in
// the output register and the block stays busy until it is taken.
module polyline_arc_length_sampler_core (
  input  logic clk,
  input  logic rst,
  pals_stream_if.sink   in_ch,
  pals_stream_if.source out_ch
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SQ    = 11'b00000000010,
    S_SQRT  = 11'b00000000100,
    S_RD0   = 11'b00000001000,
    S_CHK0  = 11'b00000010000,
    S_CHKN  = 11'b00000100000,
    S_SRCH  = 11'b00001000000,
    S_RDA   = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_LERP  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  pals_pkg::in_beat_t  cmd;
  pals_pkg::out_beat_t res;
  logic [pals_pkg::CNT_W-1:0] count;
  logic [31:0] total;
  pals_pkg::point_t prev;

  // Memory ports
  logic we;
  logic [pals_pkg::IDX_W-1:0] waddr, raddr;
  pals_pkg::point_t wdata, rdata;

  pals_ram #(.WIDTH(pals_pkg::PT_W), .DEPTH(pals_pkg::MAX_POINTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Square root datapath
  logic [63:0] sq_v, sq_r, sq_bit;
  logic [32:0] adx, ady;
  logic [32:0] adx_abs, ady_abs;
  logic        huge;
  logic [1:0]  sq_ph;
  logic [63:0] sq_sum;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [65:0] sq_trial;
  logic [32:0] len_sum;
  logic [31:0] len_next;

  // Command decode
  logic       fresh_pt, store_full, clamp_lo, clamp_hi;
  logic [1:0] idle_st;

  // Search and lerp registers
  logic [pals_pkg::CNT_W-1:0] lo, hi, mid;
  pals_pkg::point_t pa, pb;
  logic [16:0] t;
  logic [1:0]  lp;
  logic        div_start, div_done;
  logic [48:0] div_quo;
  logic [31:0] ds;
  logic [48:0] div_num;
  logic signed [32:0] sdiff;
  logic signed [50:0] lprod;
  logic signed [31:0] lres;
  logic signed [32:0] s_q;

  assign s_q = {cmd.query_s[31], cmd.query_s};
  assign mid = lo + ((hi - lo) >> 1);

  pals_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(ds),
    .done(div_done), .quo(div_quo)
  );

  // Shared 32x32 multiplier for squaring
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};
  assign sq_trial = {2'b0, sq_v} - ({2'b0, sq_r} + {2'b0, sq_bit});
  assign adx_abs = adx[32] ? (~adx + 33'd1) : adx;
  assign ady_abs = ady[32] ? (~ady + 33'd1) : ady;

  // Saturating running length after this segment
  assign len_sum  = {1'b0, total} + (huge ? {1'b0, pals_pkg::LEN_MAX} : {1'b0, sq_r[31:0]});
  assign len_next = (len_sum > {1'b0, pals_pkg::LEN_MAX}) ? pals_pkg::LEN_MAX : len_sum[31:0];

  // Classify the offered command
  assign fresh_pt   = in_ch.data.start_new || (count == '0);
  assign store_full = (count == pals_pkg::CNT_W'(pals_pkg::MAX_POINTS));
  assign clamp_lo   = $signed(s_q) <= $signed({1'b0, pa.s});
  assign clamp_hi   = $signed(s_q) >= $signed({1'b0, rdata.s});

  always_comb begin
    if (in_ch.data.op == pals_pkg::OP_SAMPLE) begin
      idle_st = (count == '0) ? pals_pkg::ST_EMPTY : pals_pkg::ST_OK;
    end else if (!fresh_pt && store_full) begin
      idle_st = pals_pkg::ST_FULL;
    end else begin
      idle_st = pals_pkg::ST_STORE;
    end
  end

  // Lerp: one field per cycle through a 33x17 signed multiply
  always_comb begin
    unique case (lp)
      2'd0: sdiff = {pb.x[31], pb.x} - {pa.x[31], pa.x};
      2'd1: sdiff = {pb.y[31], pb.y} - {pa.y[31], pa.y};
      2'd2: sdiff = 33'(signed'(pb.speed)) - 33'(signed'(pa.speed));
      default: sdiff = 33'(signed'(16'(pb.heading - pa.heading)));
    endcase
    lprod = (51'(sdiff) * signed'({34'd0, t})) + 51'sd32768;
    lres  = 32'(lprod >>> 16);
  end

  assign ds = ((pb.s - pa.s) == 32'd0) ? 32'd1 : (pb.s - pa.s);
  assign div_num = {1'b0, cmd.query_s - pa.s, 16'd0};

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = res;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.data.op == pals_pkg::OP_SAMPLE) begin
            state_next = (count == '0) ? S_OUT : S_RD0;
          end else begin
            state_next = (fresh_pt || store_full) ? S_OUT : S_SQ;
          end
        end
      end
      S_SQ:   if (sq_ph == 2'd2) state_next = S_SQRT;
      S_SQRT: if (sq_bit == 64'd0) state_next = S_OUT;
      S_RD0:  state_next = S_CHK0;
      S_CHK0: state_next = S_CHKN;
      S_CHKN: state_next = (clamp_lo || clamp_hi) ? S_OUT : S_SRCH;
      S_SRCH: if (lo >= hi && sq_ph == 2'd2) state_next = S_RDA;
      S_RDA:  state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_LERP;
      S_LERP: if (lp == 2'd3) state_next = S_OUT;
      S_OUT:  if (out_ch.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      total <= '0;
      we    <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state <= state_next;
      we <= (state == S_IDLE && in_ch.valid && in_ch.data.op == pals_pkg::OP_APPEND &&
             fresh_pt) || (state == S_SQRT && sq_bit == 64'd0);
      div_start <= (state == S_RDA);
      unique case (state)
        S_IDLE: begin
          cmd   <= in_ch.data;
          sq_ph <= 2'd0;
          raddr <= '0;
          res   <= '{status: idle_st, out_x: '0, out_y: '0, out_heading: '0,
                     out_speed: '0, out_s: '0};
          adx <= {in_ch.data.point_x[31], in_ch.data.point_x} - {prev.x[31], prev.x};
          ady <= {in_ch.data.point_y[31], in_ch.data.point_y} - {prev.y[31], prev.y};
          wdata <= '{x: in_ch.data.point_x, y: in_ch.data.point_y,
                     heading: in_ch.data.point_heading,
                     speed: in_ch.data.point_speed, s: 32'd0};
          if (in_ch.valid && in_ch.data.op == pals_pkg::OP_APPEND && fresh_pt) begin
            prev  <= '{x: in_ch.data.point_x, y: in_ch.data.point_y,
                       heading: in_ch.data.point_heading,
                       speed: in_ch.data.point_speed, s: 32'd0};
            waddr <= '0;
            count <= pals_pkg::CNT_W'(1);
            total <= '0;
          end
        end
        S_SQ: begin
          unique case (sq_ph)
            2'd0: begin
              adx   <= adx_abs;
              ady   <= ady_abs;
              mul_a <= adx_abs[31:0];
              mul_b <= adx_abs[31:0];
            end
            2'd1: begin
              huge  <= adx[31] | ady[31];
              sq_sum <= mul_p;
              mul_a <= ady[31:0];
              mul_b <= ady[31:0];
            end
            default: begin
              sq_v   <= sq_sum + mul_p;
              sq_r   <= '0;
              sq_bit <= 64'd1 << 62;
            end
          endcase
          sq_ph <= sq_ph + 2'd1;
        end
        S_SQRT: begin
          if (sq_bit != 64'd0) begin
            if (!sq_trial[65]) begin
              sq_v <= sq_trial[63:0];
              sq_r <= (sq_r >> 1) + sq_bit;
            end else begin
              sq_r <= sq_r >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end else begin
            total <= len_next;
            wdata <= '{x: cmd.point_x, y: cmd.point_y, heading: cmd.point_heading,
                       speed: cmd.point_speed, s: len_next};
            prev  <= '{x: cmd.point_x, y: cmd.point_y, heading: cmd.point_heading,
                       speed: cmd.point_speed, s: len_next};
            waddr <= count[pals_pkg::IDX_W-1:0];
            count <= count + pals_pkg::CNT_W'(1);
          end
        end
        S_RD0: raddr <= pals_pkg::IDX_W'(count - pals_pkg::CNT_W'(1));
        S_CHK0: pa <= rdata;
        S_CHKN: begin
          pb <= rdata;
          lo <= pals_pkg::CNT_W'(1);
          hi <= count - pals_pkg::CNT_W'(1);
          sq_ph <= 2'd0;
          if (clamp_lo) begin
            res <= '{status: pals_pkg::ST_OK, out_x: pa.x, out_y: pa.y,
                     out_heading: pa.heading, out_speed: pa.speed, out_s: pa.s};
          end else if (clamp_hi) begin
            res <= '{status: pals_pkg::ST_OK, out_x: rdata.x, out_y: rdata.y,
                     out_heading: rdata.heading, out_speed: rdata.speed,
                     out_s: rdata.s};
          end
        end
        S_SRCH: begin
          // Each step has three phases: issue read, wait for data, compare and narrow.
          // Once narrowed, fetch the pair at lo and lo - 1.
          unique case (sq_ph)
            2'd0: raddr <= (lo >= hi) ? pals_pkg::IDX_W'(lo) : pals_pkg::IDX_W'(mid);
            2'd1: if (lo >= hi) raddr <= pals_pkg::IDX_W'(lo - pals_pkg::CNT_W'(1));
            default: begin
              if (lo >= hi) pb <= rdata;
              else if ($signed({1'b0, rdata.s}) < $signed(s_q))
                lo <= mid + pals_pkg::CNT_W'(1);
              else hi <= mid;
            end
          endcase
          sq_ph <= (sq_ph == 2'd2) ? 2'd0 : sq_ph + 2'd1;
        end
        S_RDA: pa <= rdata;
        S_DIV: begin
          lp <= 2'd0;
          if (div_done) t <= (div_quo > 49'd65536) ? 17'd65536 : div_quo[16:0];
        end
        S_LERP: begin
          unique case (lp)
            2'd0: res.out_x <= pa.x + lres;
            2'd1: res.out_y <= pa.y + lres;
            2'd2: res.out_speed <= 16'(pa.speed + 16'(lres));
            default: begin
              res.out_heading <= 16'(pa.heading + 16'(lres));
              res.out_s  <= cmd.query_s;
              res.status <= pals_pkg::ST_OK;
            end
          endcase
          lp <= lp + 2'd1;
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: hdl/pals_checker.sv
`include "polyline_arc_length_sampler_core_assert.svh"
module pals_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status
);
  `PALS_ASSERT_IMP(a_busy_no_take, clk, rst, out_valid, !in_ready)
  `PALS_ASSERT_NXT(a_take_busy, clk, rst, in_valid && in_ready, !in_ready)
  `PALS_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status))
endmodule

bind polyline_arc_length_sampler_core pals_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.data.status)
);
